// ===== rtl/delayed_release_fifo_unit_macros.svh =====
// ----------------------------------------------------------------------------
// delayed release fifo assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef DELAYED_RELEASE_FIFO_UNIT_MACROS_SVH
`define DELAYED_RELEASE_FIFO_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DRF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drf assertion failed");

// next-cycle implication
`define DRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drf assertion failed");

`else

`define DRF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define DRF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/drf_pkg.sv =====
// ----------------------------------------------------------------------------
// drf_pkg
// shared constants, entry types and helpers of the delayed release fifo
// ----------------------------------------------------------------------------
`default_nettype none

package drf_pkg;

   // geometry
   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int TIME_W  = 64;
   localparam int DELAY_W = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(DEPTH - 1);

   // one stored entry: word plus its release time
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [TIME_W-1:0] release_time;
   } entry_type;

   // write port of the entry ram
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        entry;
   } wr_port_type;

   // ring increment with wrap at the last slot
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      next_slot = (slot == LAST_SLOT) ? '0 : slot + IDX_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/drf_entry_ram.sv =====
// ----------------------------------------------------------------------------
// drf_entry_ram
// single write, single read entry store with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module drf_entry_ram (
   input  wire logic                         clock,
   input  wire drf_pkg::wr_port_type         wr,
   input  wire logic [drf_pkg::IDX_W-1:0]    rd_addr,
   output drf_pkg::entry_type                rd_entry
);

   drf_pkg::entry_type mem [drf_pkg::DEPTH];
   drf_pkg::entry_type rd_entry_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

// ===== rtl/delayed_release_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// delayed_release_fifo_unit
// ring fifo whose entries may only leave a set number of ticks after push
// ----------------------------------------------------------------------------
// Each req transaction is one tick carrying an optional push (req_push_valid,
// req_push_data) and an optional pop (req_pop_request). Each tick returns one
// rsp transaction: push/pop outcome, the popped word, the new head word with
// its maturity for the next tick, and the fill level.
// An entry pushed at tick T may be popped at a tick no earlier than
// T + release_delay. The delay is written through the csr channel, which is
// always ready; it should only be changed while no tick is in flight.
// A taken req transaction runs through evaluation and the head stage; the
// next is taken once its response is registered, paced by the pass through
// the entry ram (head read, tail write with new head read, head result).
// A response waiting under rsp_stall does not block the next req transaction,
// which runs until its own response needs the output register.
// Reset empties the queue, clears the tick counter and sets the delay to 0;
// the entry ram itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delayed_release_fifo_unit_macros.svh"

module delayed_release_fifo_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // tick requests
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_push_valid,
   input  wire logic [drf_pkg::DATA_W-1:0]    req_push_data,
   input  wire logic                          req_pop_request,
   // tick responses
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_push_accepted,
   output logic                               rsp_pop_done,
   output logic [drf_pkg::DATA_W-1:0]         rsp_popped_data,
   output logic [drf_pkg::DATA_W-1:0]         rsp_head_data,
   output logic                               rsp_head_ready,
   output logic [drf_pkg::CNT_W-1:0]          rsp_entry_count,
   output logic                               rsp_queue_full,
   output logic                               rsp_queue_empty,
   // delay register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [drf_pkg::DELAY_W-1:0]   csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_HEAD
   } state_type;

   state_type                         state_ff, state_in;
   logic [drf_pkg::IDX_W-1:0]         head_ff, head_in;
   logic [drf_pkg::IDX_W-1:0]         tail_ff, tail_in;
   logic [drf_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [drf_pkg::TIME_W-1:0]        tick_ff, tick_in;
   logic [drf_pkg::DELAY_W-1:0]       delay_ff, delay_in;

   // latched request
   logic                              push_ff, push_in;
   logic                              pop_ff, pop_in;
   logic [drf_pkg::DATA_W-1:0]        data_ff, data_in;

   // tick outcome carried to the head stage
   logic                              push_acc_ff, push_acc_in;
   logic                              pop_done_ff, pop_done_in;
   logic [drf_pkg::DATA_W-1:0]        popped_ff, popped_in;
   logic                              fwd_ff, fwd_in;
   drf_pkg::entry_type                fwd_entry_ff, fwd_entry_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              o_push_acc_ff, o_push_acc_in;
   logic                              o_pop_done_ff, o_pop_done_in;
   logic [drf_pkg::DATA_W-1:0]        o_popped_ff, o_popped_in;
   logic [drf_pkg::DATA_W-1:0]        o_head_data_ff, o_head_data_in;
   logic                              o_head_ready_ff, o_head_ready_in;
   logic [drf_pkg::CNT_W-1:0]         o_cnt_ff, o_cnt_in;

   // ram interface
   drf_pkg::wr_port_type              ram_wr;
   logic [drf_pkg::IDX_W-1:0]         ram_rd_addr;
   drf_pkg::entry_type                ram_q;

   // evaluation stage terms
   logic                              start_empty;
   logic                              start_full;
   logic                              can_pop;
   logic                              can_push;
   logic [drf_pkg::IDX_W-1:0]         head_next;
   logic [drf_pkg::IDX_W-1:0]         tail_next;
   drf_pkg::entry_type                push_entry;

   // head stage terms
   drf_pkg::entry_type                head_entry;
   logic                              now_empty;
   logic                              out_free;
   logic                              req_take;

   drf_entry_ram u_entry_ram (
      .clock    (clock),
      .wr       (ram_wr),
      .rd_addr  (ram_rd_addr),
      .rd_entry (ram_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // pop and push decisions on the state at the start of the tick
   assign start_empty = (cnt_ff == '0);
   assign start_full  = (cnt_ff == drf_pkg::FULL_COUNT);
   assign can_pop     = pop_ff && !start_empty && (ram_q.release_time <= tick_ff);
   assign can_push    = push_ff && !start_full;
   assign head_next   = can_pop ? drf_pkg::next_slot(head_ff) : head_ff;
   assign tail_next   = can_push ? drf_pkg::next_slot(tail_ff) : tail_ff;

   assign push_entry.data         = data_ff;
   assign push_entry.release_time = tick_ff + {{(drf_pkg::TIME_W - drf_pkg::DELAY_W){1'b0}},
                                               delay_ff};

   // ram write happens only in the evaluation stage
   assign ram_wr.en    = (state_ff == ST_EVAL) && can_push;
   assign ram_wr.addr  = tail_ff;
   assign ram_wr.entry = push_entry;

   // look up the new head during evaluation, otherwise keep the current head
   assign ram_rd_addr = (state_ff == ST_EVAL) ? head_next : head_ff;

   // new head, bypassing the ram when its slot was written in the same cycle as the lookup
   assign head_entry = fwd_ff ? fwd_entry_ff : ram_q;
   assign now_empty  = (cnt_ff == '0);

   // next state logic
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      cnt_in          = cnt_ff;
      tick_in         = tick_ff;
      delay_in        = delay_ff;
      push_in         = push_ff;
      pop_in          = pop_ff;
      data_in         = data_ff;
      push_acc_in     = push_acc_ff;
      pop_done_in     = pop_done_ff;
      popped_in       = popped_ff;
      fwd_in          = fwd_ff;
      fwd_entry_in    = fwd_entry_ff;
      rsp_valid_in    = rsp_valid_ff;
      o_push_acc_in   = o_push_acc_ff;
      o_pop_done_in   = o_pop_done_ff;
      o_popped_in     = o_popped_ff;
      o_head_data_in  = o_head_data_ff;
      o_head_ready_in = o_head_ready_ff;
      o_cnt_in        = o_cnt_ff;

      // delay register write
      if (csr_valid && csr_ready) begin
         delay_in = csr_data;
      end

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               push_in  = req_push_valid;
               pop_in   = req_pop_request;
               data_in  = req_push_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            push_acc_in  = can_push;
            pop_done_in  = can_pop;
            popped_in    = can_pop ? ram_q.data : '0;
            head_in      = head_next;
            tail_in      = tail_next;
            cnt_in       = cnt_ff + drf_pkg::CNT_W'(can_push) - drf_pkg::CNT_W'(can_pop);
            tick_in      = tick_ff + drf_pkg::TIME_W'(1);
            fwd_in       = can_push && (head_next == tail_ff);
            fwd_entry_in = push_entry;
            state_in     = ST_HEAD;
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               o_push_acc_in   = push_acc_ff;
               o_pop_done_in   = pop_done_ff;
               o_popped_in     = popped_ff;
               o_head_data_in  = now_empty ? '0 : head_entry.data;
               o_head_ready_in = !now_empty && (head_entry.release_time <= tick_ff);
               o_cnt_in        = cnt_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         tick_ff      <= '0;
         delay_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         tick_ff      <= tick_in;
         delay_ff     <= delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      push_ff         <= push_in;
      pop_ff          <= pop_in;
      data_ff         <= data_in;
      push_acc_ff     <= push_acc_in;
      pop_done_ff     <= pop_done_in;
      popped_ff       <= popped_in;
      fwd_ff          <= fwd_in;
      fwd_entry_ff    <= fwd_entry_in;
      o_push_acc_ff   <= o_push_acc_in;
      o_pop_done_ff   <= o_pop_done_in;
      o_popped_ff     <= o_popped_in;
      o_head_data_ff  <= o_head_data_in;
      o_head_ready_ff <= o_head_ready_in;
      o_cnt_ff        <= o_cnt_in;
   end

   // response ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_push_accepted = o_push_acc_ff;
   assign rsp_pop_done      = o_pop_done_ff;
   assign rsp_popped_data   = o_popped_ff;
   assign rsp_head_data     = o_head_data_ff;
   assign rsp_head_ready    = o_head_ready_ff;
   assign rsp_entry_count   = o_cnt_ff;
   assign rsp_queue_full    = (o_cnt_ff == drf_pkg::FULL_COUNT);
   assign rsp_queue_empty   = (o_cnt_ff == '0);

   // fill level never passes the depth
   `DRF_ASSERT_IMPLIES(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= drf_pkg::FULL_COUNT)

   // pointers meet exactly when the ring is empty or full
   `DRF_ASSERT_IMPLIES(a_ptr_meet, clock, reset,
                       (cnt_ff == '0) || (cnt_ff == drf_pkg::FULL_COUNT),
                       head_ff == tail_ff)

   // a taken tick is evaluated in the next cycle with the tick counter still held
   `DRF_ASSERT_NEXT(a_take_eval, clock, reset, req_take,
                    (state_ff == ST_EVAL) && $stable(tick_ff))

   // a tick only advances the counter through evaluation
   `DRF_ASSERT_NEXT(a_tick_step, clock, reset, state_ff != ST_EVAL, $stable(tick_ff))

endmodule

`default_nettype wire
